// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_IMPLIES_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)

`define ASSERT_IMPLIES(label, ante, cons, msg)

`define ASSERT_IMPLIES_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/cflid_pkg.sv =====
// ----------------------------------------------------------------------------
// cflid_pkg
// Types, widths, codes and helpers of the fractional-delay comb filter.
// ----------------------------------------------------------------------------
package cflid_pkg;

	localparam int DEPTH       = 65536;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = $clog2(DEPTH);

	localparam int DELAY_W   = 25;
	localparam int FB_W      = 24;
	localparam int SHIFT_W   = 4;
	localparam int CD_W      = 26;
	localparam int CF_W      = 25;
	localparam int DIFF_W    = 26;
	localparam int RAMP_W    = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 25;

	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;
	localparam logic [RAMP_W-1:0]  RAMP_MAX  = RAMP_W'(1 << 12);

	localparam logic [DELAY_W-1:0] DELAY_MIN = DELAY_W'(256);
	localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(DEPTH * 256);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic signed [CD_W-1:0]        cur_delay_t;
	typedef logic signed [CF_W-1:0]        cur_fb_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY    = 2'd0,
		CFG_FEEDBACK = 2'd1,
		CFG_RAMP     = 2'd2
	} cfg_reg_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_STEP = 7'b0000010,
		ST_RD1  = 7'b0000100,
		ST_RD2  = 7'b0001000,
		ST_MIX  = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_WR   = 7'b1000000
	} state_t;

	function automatic cur_delay_t delay_clamp(input logic [DELAY_W-1:0] v);
		cur_delay_t r;
		if (v < DELAY_MIN)
			r = CD_W'(DELAY_MIN);
		else if (v > DELAY_MAX)
			r = CD_W'(DELAY_MAX);
		else
			r = CD_W'(v);
		return r;
	endfunction

	function automatic cur_fb_t fb_extend(input logic [FB_W-1:0] v);
		logic signed [FB_W-1:0] s;
		s = signed'(v);
		return CF_W'(s);
	endfunction

	function automatic sample_t sat_sample(input logic signed [SAMPLE_BITS+3:0] v);
		localparam logic signed [SAMPLE_BITS+3:0] HI = (SAMPLE_BITS+4)'((1 << (SAMPLE_BITS-1)) - 1);
		localparam logic signed [SAMPLE_BITS+3:0] LO = -HI - (SAMPLE_BITS+4)'(1);
		sample_t r;
		if (v > HI)
			r = SAMPLE_BITS'(HI);
		else if (v < LO)
			r = SAMPLE_BITS'(LO);
		else
			r = SAMPLE_BITS'(v);
		return r;
	endfunction

endpackage

// ===== design/cflid_if.sv =====
// ----------------------------------------------------------------------------
// cflid_if
// Valid/ready channels of the comb filter: sample in, sample out, config.
// ----------------------------------------------------------------------------
interface cflid_in_if;
	logic                    valid;
	logic                    ready;
	cflid_pkg::sample_t      sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface cflid_out_if;
	logic                    valid;
	logic                    ready;
	cflid_pkg::sample_t      sample_out;
	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

interface cflid_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cflid_pkg::CFG_IDX_W-1:0]   index;
	logic [cflid_pkg::CFG_W-1:0]       data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/comb_filter_linear_interp_delay_core.sv =====
// ----------------------------------------------------------------------------
// comb_filter_linear_interp_delay_core
// Feedback comb filter, fractional delay read by linear interpolation.
// ----------------------------------------------------------------------------
// din carries one sample per beat, dout one filtered sample per input beat,
// cfg writes delay_length (0), feedback_coef (1) and ramp_shift (2); other
// indexes are dropped. cfg is always ready; write it while the block is idle.
// Each sample runs through these steps, from its beat on din to the next din beat:
// accept, ramp update, two reads of the single-port delay store (current
// and previous tap), interpolation, feedback multiply, write back.
// The result is loaded into the dout register as the multiply step ends
// and the write back step begins.
// dout is a holding register: a new sample is taken while a result waits,
// and the sequencer only stops at the multiply step if dout is still full.
// Reset clears control state and makes the whole store read as zero at once:
// entries not yet written since reset are masked by the write pointer and a
// wrap flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module comb_filter_linear_interp_delay_core (
	input  logic         clk,
	input  logic         arst_n,
	cflid_in_if.sink     din,
	cflid_out_if.source  dout,
	cflid_cfg_if.sink    cfg
);

	localparam int MIX_W = cflid_pkg::SAMPLE_BITS + 10;
	localparam int PRD_W = cflid_pkg::SAMPLE_BITS + cflid_pkg::CF_W;
	localparam int WR_W  = cflid_pkg::SAMPLE_BITS + 4;
	localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(128);
	localparam logic signed [PRD_W-1:0] FB_HALF  = PRD_W'(1 << 21);

	cflid_pkg::state_t              state_q;
	logic [cflid_pkg::DELAY_W-1:0]  reg_delay_q;
	logic [cflid_pkg::FB_W-1:0]     reg_fb_q;
	logic [cflid_pkg::SHIFT_W-1:0]  reg_shift_q;
	logic [cflid_pkg::DELAY_W-1:0]  seen_delay_q;
	logic [cflid_pkg::FB_W-1:0]     seen_fb_q;
	logic                           started_q;
	cflid_pkg::cur_delay_t          cur_delay_q;
	cflid_pkg::cur_fb_t             cur_fb_q;
	logic signed [cflid_pkg::DIFF_W-1:0] delay_step_q;
	logic signed [cflid_pkg::DIFF_W-1:0] fb_step_q;
	logic [cflid_pkg::RAMP_W-1:0]   ramp_left_q;
	cflid_pkg::addr_t               wp_q;
	logic                           wrapped_q;
	logic                           rvalid_q;
	logic                           out_valid_q;

	cflid_pkg::sample_t             x_q;
	cflid_pkg::sample_t             r1_q;
	cflid_pkg::sample_t             rd_q;
	cflid_pkg::sample_t             out_data_q;
	cflid_pkg::sample_t             rdata_q;
	logic signed [PRD_W-1:0]        prod_q;
	logic [cflid_pkg::SAMPLE_BITS-1:0] store_q [cflid_pkg::DEPTH];

	logic                           accept;
	logic                           out_free;
	logic [cflid_pkg::SHIFT_W-1:0]  sh;
	cflid_pkg::cur_delay_t          tgt_delay;
	cflid_pkg::cur_fb_t             tgt_fb;
	logic signed [cflid_pkg::DIFF_W-1:0] d_diff;
	logic signed [cflid_pkg::DIFF_W-1:0] f_diff;
	cflid_pkg::addr_t               tap_idx;
	cflid_pkg::addr_t               p1;
	cflid_pkg::addr_t               raddr;
	logic                           re;
	logic                           we;
	cflid_pkg::sample_t             rmask;
	logic signed [cflid_pkg::SAMPLE_BITS:0] dlt;
	logic signed [8:0]              frac_s;
	logic signed [MIX_W-1:0]        mix_prod;
	logic signed [MIX_W-1:0]        mix_sum;
	logic signed [MIX_W-1:0]        mix_rnd;
	logic signed [cflid_pkg::SAMPLE_BITS:0] rd_full;
	logic signed [PRD_W-1:0]        fb_sum;
	logic signed [PRD_W-1:0]        fb_rnd;
	logic signed [WR_W-1:0]         wr_full;
	cflid_pkg::sample_t             wr_data;

	assign accept    = din.valid && din.ready;
	assign din.ready = (state_q == cflid_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_data_q;
	assign out_free  = !out_valid_q || dout.ready;

	always_comb begin
		sh        = (reg_shift_q > cflid_pkg::SHIFT_MAX) ? cflid_pkg::SHIFT_MAX : reg_shift_q;
		tgt_delay = cflid_pkg::delay_clamp(reg_delay_q);
		tgt_fb    = cflid_pkg::fb_extend(reg_fb_q);
		d_diff    = cflid_pkg::DIFF_W'(tgt_delay) - cflid_pkg::DIFF_W'(cur_delay_q);
		f_diff    = cflid_pkg::DIFF_W'(tgt_fb) - cflid_pkg::DIFF_W'(cur_fb_q);
	end

	// read taps: p1 = wp - int(delay), p2 = p1 - 1
	always_comb begin
		tap_idx = cur_delay_q[cflid_pkg::ADDR_W+7:8];
		p1      = wp_q - tap_idx;
		re      = (state_q == cflid_pkg::ST_RD1) || (state_q == cflid_pkg::ST_RD2);
		raddr   = (state_q == cflid_pkg::ST_RD2) ? (p1 - cflid_pkg::ADDR_W'(1)) : p1;
		we      = (state_q == cflid_pkg::ST_WR);
		rmask   = rvalid_q ? rdata_q : '0;
	end

	always_comb begin
		dlt      = (cflid_pkg::SAMPLE_BITS+1)'(rmask) - (cflid_pkg::SAMPLE_BITS+1)'(r1_q);
		frac_s   = {1'b0, cur_delay_q[7:0]};
		mix_prod = MIX_W'(dlt) * MIX_W'(frac_s);
		mix_sum  = mix_prod + MIX_HALF;
		mix_rnd  = mix_sum >>> 8;
		rd_full  = (cflid_pkg::SAMPLE_BITS+1)'(r1_q)
			+ (cflid_pkg::SAMPLE_BITS+1)'(mix_rnd);
		fb_sum   = prod_q + FB_HALF;
		fb_rnd   = fb_sum >>> 22;
		wr_full  = WR_W'(fb_rnd) + WR_W'(x_q);
		wr_data  = cflid_pkg::sat_sample(wr_full);
	end

	always_ff @(posedge clk) begin
		if (we)
			store_q[wp_q] <= wr_data;
		if (re)
			rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (accept)
			x_q <= din.sample_in;
		if (state_q == cflid_pkg::ST_RD2)
			r1_q <= rmask;
		if (state_q == cflid_pkg::ST_MIX)
			rd_q <= cflid_pkg::SAMPLE_BITS'(rd_full);
		if (state_q == cflid_pkg::ST_MUL)
			prod_q <= PRD_W'(rd_q) * PRD_W'(cur_fb_q);
		if (state_q == cflid_pkg::ST_MUL && out_free)
			out_data_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_delay_q <= cflid_pkg::DELAY_MIN;
			reg_fb_q    <= '0;
			reg_shift_q <= cflid_pkg::SHIFT_W'(6);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				cflid_pkg::CFG_DELAY:    reg_delay_q <= cfg.data[cflid_pkg::DELAY_W-1:0];
				cflid_pkg::CFG_FEEDBACK: reg_fb_q    <= cfg.data[cflid_pkg::FB_W-1:0];
				cflid_pkg::CFG_RAMP:     reg_shift_q <= cfg.data[cflid_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cflid_pkg::ST_IDLE;
			seen_delay_q <= cflid_pkg::DELAY_MIN;
			seen_fb_q    <= '0;
			started_q    <= 1'b0;
			cur_delay_q  <= cflid_pkg::CD_W'(cflid_pkg::DELAY_MIN);
			cur_fb_q     <= '0;
			delay_step_q <= '0;
			fb_step_q    <= '0;
			ramp_left_q  <= '0;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			rvalid_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == cflid_pkg::ST_MUL && out_free)
				out_valid_q <= 1'b1;
			else if (dout.ready)
				out_valid_q <= 1'b0;
			if (re)
				rvalid_q <= wrapped_q || (raddr < wp_q);
			unique case (state_q)
				cflid_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= cflid_pkg::ST_STEP;
						if (!started_q) begin
							started_q    <= 1'b1;
							seen_delay_q <= reg_delay_q;
							seen_fb_q    <= reg_fb_q;
							cur_delay_q  <= tgt_delay;
							cur_fb_q     <= tgt_fb;
							ramp_left_q  <= '0;
							delay_step_q <= '0;
							fb_step_q    <= '0;
						end else if (reg_delay_q != seen_delay_q || reg_fb_q != seen_fb_q) begin
							seen_delay_q <= reg_delay_q;
							seen_fb_q    <= reg_fb_q;
							ramp_left_q  <= cflid_pkg::RAMP_W'(1) << sh;
							delay_step_q <= d_diff >>> sh;
							fb_step_q    <= f_diff >>> sh;
						end
					end
				end
				cflid_pkg::ST_STEP: begin
					state_q <= cflid_pkg::ST_RD1;
					if (ramp_left_q != '0) begin
						ramp_left_q <= ramp_left_q - cflid_pkg::RAMP_W'(1);
						if (ramp_left_q == cflid_pkg::RAMP_W'(1)) begin
							cur_delay_q <= cflid_pkg::delay_clamp(seen_delay_q);
							cur_fb_q    <= cflid_pkg::fb_extend(seen_fb_q);
						end else begin
							cur_delay_q <= cur_delay_q + cflid_pkg::CD_W'(delay_step_q);
							cur_fb_q    <= cur_fb_q + cflid_pkg::CF_W'(fb_step_q);
						end
					end
				end
				cflid_pkg::ST_RD1: state_q <= cflid_pkg::ST_RD2;
				cflid_pkg::ST_RD2: state_q <= cflid_pkg::ST_MIX;
				cflid_pkg::ST_MIX: state_q <= cflid_pkg::ST_MUL;
				cflid_pkg::ST_MUL: begin
					if (out_free)
						state_q <= cflid_pkg::ST_WR;
				end
				cflid_pkg::ST_WR: begin
					state_q <= cflid_pkg::ST_IDLE;
					wp_q    <= wp_q + cflid_pkg::ADDR_W'(1);
					if (wp_q == cflid_pkg::ADDR_W'(cflid_pkg::DEPTH - 1))
						wrapped_q <= 1'b1;
				end
				default: state_q <= cflid_pkg::ST_IDLE;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_ramp_bound, ramp_left_q <= cflid_pkg::RAMP_MAX, "ramp count out of range")
	`ASSERT_IMPLIES_NEXT(a_accept_step, accept, state_q == cflid_pkg::ST_STEP, "accept did not start a sample")
	`ASSERT_IMPLIES(a_out_from_mul, $rose(out_valid_q), $past(state_q) == cflid_pkg::ST_MUL, "result beat outside multiply step")
	`ASSERT_IMPLIES_NEXT(a_wp_advance, state_q == cflid_pkg::ST_WR, wp_q == cflid_pkg::ADDR_W'($past(wp_q) + 1'b1), "write pointer did not advance")

endmodule
